// File: sv/rhwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhwf_pkg
// Shared types, codes and the microprogram of the right-hand wall follower.
// ----------------------------------------------------------------------------
package rhwf_pkg;

  // Request codes carried by in_req_type.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  // Heading codes.
  localparam logic [1:0] HD_UP    = 2'd0;
  localparam logic [1:0] HD_RIGHT = 2'd1;
  localparam logic [1:0] HD_DOWN  = 2'd2;
  localparam logic [1:0] HD_LEFT  = 2'd3;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_IDLE   = 4'd0,
    OP_NOP    = 4'd1,
    OP_TURN_R = 4'd2,
    OP_READ   = 4'd3,
    OP_TURN_L = 4'd4,
    OP_STUCK  = 4'd5,
    OP_WRITE  = 4'd6,
    OP_START  = 4'd7,
    OP_MOVE   = 4'd8,
    OP_REPORT = 4'd9
  } op_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_NOACC    = 3'd2,
    C_IS_WRITE = 3'd3,
    C_IS_START = 3'd4,
    C_NOT_STEP = 3'd5,
    C_FREE     = 3'd6,
    C_MORE     = 3'd7
  } cond_t;

  typedef logic [3:0] uaddr_t;

  typedef struct packed {
    op_t    op;
    cond_t  cond;
    uaddr_t target;
  } ucode_t;

  // Status returned by the datapath to the sequencer.
  typedef struct packed {
    logic accept;
    logic is_write;
    logic is_start;
    logic not_step;
    logic free;
    logic more;
    logic stall;
  } stat_t;

  // Microprogram addresses.
  localparam uaddr_t U_IDLE     = 4'd0;
  localparam uaddr_t U_DISP_WR  = 4'd1;
  localparam uaddr_t U_DISP_ST  = 4'd2;
  localparam uaddr_t U_RIGHT    = 4'd3;
  localparam uaddr_t U_PROBE    = 4'd4;
  localparam uaddr_t U_TEST     = 4'd5;
  localparam uaddr_t U_LEFT     = 4'd6;
  localparam uaddr_t U_STUCK    = 4'd7;
  localparam uaddr_t U_WRITE    = 4'd8;
  localparam uaddr_t U_START    = 4'd9;
  localparam uaddr_t U_MOVE     = 4'd10;
  localparam uaddr_t U_REPORT   = 4'd11;

  // A taken condition jumps to the target, otherwise the step counter advances.
  function automatic ucode_t ucode_rom(input uaddr_t addr);
    ucode_t w;
    case (addr)
      U_IDLE:    w = '{op: OP_IDLE,   cond: C_NOACC,    target: U_IDLE};
      U_DISP_WR: w = '{op: OP_NOP,    cond: C_IS_WRITE, target: U_WRITE};
      U_DISP_ST: w = '{op: OP_NOP,    cond: C_IS_START, target: U_START};
      U_RIGHT:   w = '{op: OP_TURN_R, cond: C_NOT_STEP, target: U_REPORT};
      U_PROBE:   w = '{op: OP_READ,   cond: C_NEVER,    target: U_IDLE};
      U_TEST:    w = '{op: OP_NOP,    cond: C_FREE,     target: U_MOVE};
      U_LEFT:    w = '{op: OP_TURN_L, cond: C_MORE,     target: U_PROBE};
      U_STUCK:   w = '{op: OP_STUCK,  cond: C_ALWAYS,   target: U_REPORT};
      U_WRITE:   w = '{op: OP_WRITE,  cond: C_ALWAYS,   target: U_REPORT};
      U_START:   w = '{op: OP_START,  cond: C_ALWAYS,   target: U_REPORT};
      U_MOVE:    w = '{op: OP_MOVE,   cond: C_NEVER,    target: U_IDLE};
      U_REPORT:  w = '{op: OP_REPORT, cond: C_ALWAYS,   target: U_IDLE};
      default:   w = '{op: OP_NOP,    cond: C_ALWAYS,   target: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: sv/right_hand_wall_follower.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// right_hand_wall_follower
// Right-hand rule maze walker over a one-bit wall map, run by a microcoded
// sequencer driving a small datapath with the wall memory.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Word
//  in_      in_valid/in_ready    req_type, tile_x, tile_y, wall_bit, start_heading
//  out_     out_valid/out_ready  pos_x, pos_y, heading, in_maze, stuck
//
//  A tile write and a start each pass the dispatch steps, their own step and
//  the report step. A step makes one wall probe, a memory read through the
//  single read port, per direction tried, at most four; it reports stuck when
//  all four are walls. After reset the wall memory is cleared one entry a cycle,
//  all 2^(2*clog2(GRID_SIZE)) entries (256 at the default), while in_ready stays low.
//  A new word is accepted while the previous result waits; the sequencer only
//  holds at its report step when the result register is still full.
// ----------------------------------------------------------------------------
module right_hand_wall_follower #(
  parameter int GRID_SIZE = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [3:0] in_tile_x,
  input  logic [3:0] in_tile_y,
  input  logic       in_wall_bit,
  input  logic [1:0] in_start_heading,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_pos_x,
  output logic [3:0] out_pos_y,
  output logic [1:0] out_heading,
  output logic       out_in_maze,
  output logic       out_stuck
);
  import rhwf_pkg::*;

  ucode_t ctrl;
  stat_t  stat;

  rhwf_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  rhwf_dpath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_tile_x        (in_tile_x),
    .in_tile_y        (in_tile_y),
    .in_wall_bit      (in_wall_bit),
    .in_start_heading (in_start_heading),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_heading      (out_heading),
    .out_in_maze      (out_in_maze),
    .out_stuck        (out_stuck)
  );

endmodule

// File: sv/rhwf_useq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhwf_useq
// Microcode sequencer: step counter, program table and conditional jumps.
// ----------------------------------------------------------------------------
module rhwf_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  rhwf_pkg::stat_t stat,
  output rhwf_pkg::ucode_t ctrl
);
  import rhwf_pkg::*;

  uaddr_t upc_r;
  uaddr_t upc_nxt;
  ucode_t cw;
  logic   take;

  assign cw   = ucode_rom(upc_r);
  assign ctrl = cw;

  always_comb begin
    case (cw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NOACC:    take = !stat.accept;
      C_IS_WRITE: take = stat.is_write;
      C_IS_START: take = stat.is_start;
      C_NOT_STEP: take = stat.not_step;
      C_FREE:     take = stat.free;
      C_MORE:     take = stat.more;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    if (stat.stall) begin
      upc_nxt = upc_r;
    end else if (take) begin
      upc_nxt = cw.target;
    end else begin
      upc_nxt = upc_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// File: sv/rhwf_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhwf_dpath
// Datapath: request latch, walker registers, wall memory with clearing pass
// and the result register.
// ----------------------------------------------------------------------------
module rhwf_dpath #(
  parameter int GRID_SIZE = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rhwf_pkg::ucode_t ctrl,
  output rhwf_pkg::stat_t  stat,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_req_type,
  input  logic [3:0]       in_tile_x,
  input  logic [3:0]       in_tile_y,
  input  logic             in_wall_bit,
  input  logic [1:0]       in_start_heading,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [3:0]       out_pos_x,
  output logic [3:0]       out_pos_y,
  output logic [1:0]       out_heading,
  output logic             out_in_maze,
  output logic             out_stuck
);
  import rhwf_pkg::*;

  localparam int AW = $clog2(GRID_SIZE);
  localparam int CW = (AW > 4) ? AW : 4;
  localparam int MW = 2 * AW;
  localparam int MD = 1 << MW;
  localparam logic [CW:0]   GS      = (CW + 1)'(GRID_SIZE);
  localparam logic [CW-1:0] LAST    = CW'(GRID_SIZE - 1);
  localparam logic [MW-1:0] MEM_TOP = MW'(MD - 1);

  logic wall_mem [MD];

  logic [1:0]    req_r;
  logic [3:0]    tx_r, ty_r;
  logic          wb_r;
  logic [1:0]    sh_r;
  logic [CW-1:0] wx_r, wy_r;
  logic [1:0]    whd_r;
  logic [1:0]    h_r;
  logic [1:0]    probe_r;
  logic          stuck_r;
  logic          rd_r;
  logic          clr_r;
  logic [MW-1:0] clr_cnt_r;
  logic          out_valid_r;
  logic [3:0]    out_x_r, out_y_r;
  logic [1:0]    out_hd_r;
  logic          out_in_r, out_stuck_r;

  logic          accept;
  logic          interior;
  logic [CW-1:0] tx_w, ty_w;
  logic          tx_in, ty_in;
  logic          start_ok;
  logic [CW-1:0] start_x, start_y;
  logic [CW-1:0] nb_x, nb_y;
  logic          stall;

  assign in_ready = (ctrl.op == OP_IDLE) && !clr_r;
  assign accept   = in_valid && in_ready;

  assign interior = (wx_r != '0) && (wx_r < LAST) && (wy_r != '0) && (wy_r < LAST);

  assign tx_w  = CW'(tx_r);
  assign ty_w  = CW'(ty_r);
  assign tx_in = {1'b0, tx_w} < GS;
  assign ty_in = {1'b0, ty_w} < GS;

  // The start move is refused when the tile ahead lies off the grid.
  always_comb begin
    start_x = tx_w;
    start_y = ty_w;
    case (sh_r)
      HD_UP: begin
        start_ok = tx_in && (ty_w != '0) && ({1'b0, ty_w} <= GS);
        start_y  = ty_w - 1'b1;
      end
      HD_RIGHT: begin
        start_ok = ty_in && (tx_w < LAST);
        start_x  = tx_w + 1'b1;
      end
      HD_DOWN: begin
        start_ok = tx_in && (ty_w < LAST);
        start_y  = ty_w + 1'b1;
      end
      HD_LEFT: begin
        start_ok = ty_in && (tx_w != '0) && ({1'b0, tx_w} <= GS);
        start_x  = tx_w - 1'b1;
      end
      default: start_ok = 1'b0;
    endcase
  end

  // Neighbour of the walker in the probe direction; the walker is interior here.
  always_comb begin
    nb_x = wx_r;
    nb_y = wy_r;
    case (h_r)
      HD_UP:    nb_y = wy_r - 1'b1;
      HD_RIGHT: nb_x = wx_r + 1'b1;
      HD_DOWN:  nb_y = wy_r + 1'b1;
      HD_LEFT:  nb_x = wx_r - 1'b1;
      default:  nb_x = wx_r;
    endcase
  end

  assign stall = (ctrl.op == OP_REPORT) && out_valid_r && !out_ready;

  assign stat = '{
    accept:   accept,
    is_write: req_r == REQ_WRITE,
    is_start: req_r == REQ_START,
    not_step: (req_r != REQ_STEP) || !interior,
    free:     !rd_r,
    more:     probe_r != 2'd3,
    stall:    stall
  };

  // Wall memory: the clearing pass owns the write port after reset.
  always_ff @(posedge clk) begin
    if (clr_r) begin
      wall_mem[clr_cnt_r] <= 1'b0;
    end else if ((ctrl.op == OP_WRITE) && tx_in && ty_in) begin
      wall_mem[{ty_w[AW-1:0], tx_w[AW-1:0]}] <= wb_r;
    end
    if (ctrl.op == OP_READ) begin
      rd_r <= wall_mem[{nb_y[AW-1:0], nb_x[AW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == MEM_TOP) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Request latch and scratch registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      tx_r    <= in_tile_x;
      ty_r    <= in_tile_y;
      wb_r    <= in_wall_bit;
      sh_r    <= in_start_heading;
      stuck_r <= 1'b0;
    end
    case (ctrl.op)
      OP_TURN_R: begin
        h_r     <= whd_r + 2'd1;
        probe_r <= 2'd0;
      end
      OP_TURN_L: begin
        h_r     <= h_r - 2'd1;
        probe_r <= probe_r + 2'd1;
      end
      OP_STUCK: stuck_r <= 1'b1;
      default:  ;
    endcase
  end

  // Walker state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wx_r  <= '0;
      wy_r  <= '0;
      whd_r <= HD_UP;
    end else begin
      case (ctrl.op)
        OP_START: begin
          whd_r <= sh_r;
          wx_r  <= start_ok ? start_x : tx_w;
          wy_r  <= start_ok ? start_y : ty_w;
        end
        OP_MOVE: begin
          whd_r <= h_r;
          wx_r  <= nb_x;
          wy_r  <= nb_y;
        end
        default: ;
      endcase
    end
  end

  // Result register: a new word may load in the cycle the old one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctrl.op == OP_REPORT) && !stall) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.op == OP_REPORT) && !stall) begin
      out_x_r     <= wx_r[3:0];
      out_y_r     <= wy_r[3:0];
      out_hd_r    <= whd_r;
      out_in_r    <= interior;
      out_stuck_r <= stuck_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pos_x   = out_x_r;
  assign out_pos_y   = out_y_r;
  assign out_heading = out_hd_r;
  assign out_in_maze = out_in_r;
  assign out_stuck   = out_stuck_r;

endmodule
